// File: sv/gsps_pkg.sv
// ----------------------------------------------------------------------------
// gsps_pkg
// Shared types and constants for the gain-scheduled PD steering unit:
// sequencer states, gain bands, command and status groups, fixed-point
// constants.
// ----------------------------------------------------------------------------
package gsps_pkg;

    // Field widths
    localparam int OFFSET_W = 9;
    localparam int DATA_W   = 16;
    localparam int TENTHS_W = 24;

    // Gain band limits on |offset|
    localparam int MAG_LOW_LIM = 6;
    localparam int MAG_MID_LIM = 26;

    // Gains in tenths
    localparam int KP_LOW       = 60;
    localparam int KP_MID_BASE  = 158;
    localparam int KP_HIGH_BASE = 162;
    localparam int KD_LOW       = 50;
    localparam int KD_MID       = 100;
    localparam int KD_HIGH      = 50;

    // Square divisors and their reciprocals (scaled by 2^RECIP_SHIFT, rounded down)
    localparam int DIV_MID     = 100;
    localparam int DIV_HIGH    = 500;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_MID   = 655;
    localparam int RECIP_HIGH  = 131;

    // Tenths to whole units: reciprocal of ten scaled by 2^TEN_SHIFT
    localparam int TEN_SHIFT  = 24;
    localparam int RECIP_TEN  = 1677721;
    localparam int SAT_TENTHS = 655360;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_QUOT,
        ST_REMAIN,
        ST_GAIN,
        ST_PROD,
        ST_SUM,
        ST_SCALE,
        ST_EMIT
    } gsps_state_t;

    // Gain bands
    typedef enum logic [1:0] {
        BAND_LOW,
        BAND_MID,
        BAND_HIGH
    } gsps_band_t;

    // Sequencer to datapath commands
    typedef struct packed {
        logic load;
        logic square;
        logic quot;
        logic remain;
        logic gain;
        logic prod;
        logic sum;
        logic scale;
        logic emit;
    } gsps_cmd_t;

    // Datapath to sequencer status
    typedef struct packed {
        logic out_free;
    } gsps_stat_t;

endpackage

// File: sv/gsps_ctrl.sv
// ----------------------------------------------------------------------------
// gsps_ctrl
// Sequencer: accepts one item at a time, steps a usable one through square, quotient,
// remainder, gain, product, sum and scaling, and emits each result (a bad one directly).
// ----------------------------------------------------------------------------
module gsps_ctrl
    import gsps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,     // frame_ok
    output logic       s_tready,
    input  gsps_stat_t stat,
    output gsps_cmd_t  cmd
);

    gsps_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = s_tuser ? ST_SQUARE : ST_EMIT;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_QUOT;
            end
            ST_QUOT: begin
                cmd.quot   = 1'b1;
                state_next = ST_REMAIN;
            end
            ST_REMAIN: begin
                cmd.remain = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register can take the item
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result emitted over a pending item");

    a_bad_frame_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser) |=> (state_reg == ST_EMIT))
        else $error("bad frame did not go straight to emit");

    a_good_frame_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == ST_SQUARE))
        else $error("usable frame did not start the computation");

    a_emit_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after emit");
`endif

endmodule

// File: sv/gsps_dp.sv
// ----------------------------------------------------------------------------
// gsps_dp
// Datapath: gain scheduling from the squared offset, PD products in tenths,
// scaling to whole units with saturation, output history and output register.
// ----------------------------------------------------------------------------
module gsps_dp
    import gsps_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gsps_cmd_t                  cmd,
    output gsps_stat_t                 stat,
    input  logic signed [OFFSET_W-1:0] in_offset,
    input  logic                       in_frame_ok,
    input  logic [DATA_W-1:0]          center,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [DATA_W-1:0]          m_data
);

    // Operand and state registers
    logic signed [OFFSET_W-1:0] offset_reg;
    logic                       ok_reg;
    logic signed [OFFSET_W-1:0] prev_reg;
    logic [DATA_W-1:0]          hist_older_reg;
    logic [DATA_W-1:0]          hist_newer_reg;

    // Pipeline of the computation
    gsps_band_t                 band_reg;
    logic [16:0]                sq_reg;
    logic signed [9:0]          diff_reg;
    logic [10:0]                q0_reg;
    logic [9:0]                 rem_reg;
    logic signed [16:0]         prod_d_reg;
    logic [10:0]                kp_reg;
    logic signed [20:0]         prod_p_reg;
    logic signed [TENTHS_W-1:0] tenths_reg;
    logic                       sat_low_reg;
    logic                       sat_high_reg;
    logic [19:0]                t20_reg;
    logic [DATA_W-1:0]          tq_reg;

    // Output register
    logic                       m_valid_reg;
    logic [DATA_W-1:0]          m_data_reg;

    // Combinational helpers
    logic [OFFSET_W-1:0] mag;
    logic [9:0]          recip;
    logic [8:0]          divisor;
    logic [6:0]          kd;
    logic [26:0]         quot_prod;
    logic [10:0]         q_fixed;
    logic [40:0]         ten_prod;
    logic [4:0]          ten_rem;
    logic [DATA_W-1:0]   scaled;
    logic [DATA_W:0]     hist_sum;
    logic [DATA_W-1:0]   steer;
    logic [20:0]         center10;

    // Magnitude of the offset (-256 maps to 256)
    assign mag = offset_reg[OFFSET_W-1] ? (~offset_reg + 1'b1) : offset_reg;

    // Band constants
    always_comb begin
        unique case (band_reg)
            BAND_LOW: begin
                recip   = 10'(RECIP_HIGH);
                divisor = 9'(DIV_HIGH);
                kd      = 7'(KD_LOW);
            end
            BAND_MID: begin
                recip   = 10'(RECIP_MID);
                divisor = 9'(DIV_MID);
                kd      = 7'(KD_MID);
            end
            BAND_HIGH: begin
                recip   = 10'(RECIP_HIGH);
                divisor = 9'(DIV_HIGH);
                kd      = 7'(KD_HIGH);
            end
            default: begin
                recip   = 10'(RECIP_HIGH);
                divisor = 9'(DIV_HIGH);
                kd      = 7'(KD_HIGH);
            end
        endcase
    end

    // Quotient estimate of the square, at most one low
    assign quot_prod = {10'b0, sq_reg} * {17'b0, recip};
    assign q_fixed   = q0_reg + 11'(rem_reg >= {1'b0, divisor});

    // Tenths to units: estimate, then one correction step
    assign ten_prod = {21'b0, tenths_reg[19:0]} * 41'(RECIP_TEN);
    assign ten_rem  = 5'(t20_reg - 20'({4'b0, tq_reg} * 20'd10));
    assign scaled   = sat_low_reg  ? '0 :
                      sat_high_reg ? '1 :
                      (tq_reg + DATA_W'(ten_rem >= 5'd10));

    // Mean of the last two outputs for a bad frame
    assign hist_sum = {1'b0, hist_older_reg} + {1'b0, hist_newer_reg};
    assign steer    = ok_reg ? scaled : hist_sum[DATA_W:1];

    assign center10 = {2'b0, center, 3'b0} + {4'b0, center, 1'b0};

    // Latch the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            offset_reg <= in_offset;
            ok_reg     <= in_frame_ok;
        end
    end

    // Square, band and derivative difference
    always_ff @(posedge aclk) begin
        if (cmd.square) begin
            sq_reg   <= {8'b0, mag} * {8'b0, mag};
            diff_reg <= {offset_reg[OFFSET_W-1], offset_reg}
                      - {prev_reg[OFFSET_W-1], prev_reg};
            if (mag < 9'(MAG_LOW_LIM)) begin
                band_reg <= BAND_LOW;
            end else if (mag < 9'(MAG_MID_LIM)) begin
                band_reg <= BAND_MID;
            end else begin
                band_reg <= BAND_HIGH;
            end
        end
    end

    // Quotient estimate
    always_ff @(posedge aclk) begin
        if (cmd.quot) begin
            q0_reg <= quot_prod[RECIP_SHIFT+10:RECIP_SHIFT];
        end
    end

    // Remainder and derivative product
    always_ff @(posedge aclk) begin
        if (cmd.remain) begin
            rem_reg    <= 10'(sq_reg - 17'({9'b0, q0_reg} * {11'b0, divisor}));
            prod_d_reg <= $signed({1'b0, kd}) * diff_reg;
        end
    end

    // Proportional gain in tenths
    always_ff @(posedge aclk) begin
        if (cmd.gain) begin
            unique case (band_reg)
                BAND_LOW:  kp_reg <= 11'(KP_LOW);
                BAND_MID:  kp_reg <= 11'(KP_MID_BASE) + 11'(q_fixed * 11'd10);
                BAND_HIGH: kp_reg <= 11'(KP_HIGH_BASE) + 11'(q_fixed * 11'd10);
                default:   kp_reg <= 11'(KP_HIGH_BASE) + 11'(q_fixed * 11'd10);
            endcase
        end
    end

    // Proportional product
    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            prod_p_reg <= $signed({1'b0, kp_reg}) * offset_reg;
        end
    end

    // Drive in tenths
    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            tenths_reg <= $signed({3'b0, center10})
                        + TENTHS_W'(prod_p_reg)
                        + TENTHS_W'(prod_d_reg);
        end
    end

    // Saturation flags and unit estimate
    always_ff @(posedge aclk) begin
        if (cmd.scale) begin
            sat_low_reg  <= tenths_reg[TENTHS_W-1];
            sat_high_reg <= !tenths_reg[TENTHS_W-1]
                         && (tenths_reg >= TENTHS_W'(SAT_TENTHS));
            t20_reg      <= tenths_reg[19:0];
            tq_reg       <= ten_prod[TEN_SHIFT+DATA_W-1:TEN_SHIFT];
        end
    end

    // Advance history on emit, and the previous offset only for a usable frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            hist_older_reg <= '0;
            hist_newer_reg <= '0;
        end else if (cmd.emit) begin
            hist_older_reg <= hist_newer_reg;
            hist_newer_reg <= steer;
            if (ok_reg) begin
                prev_reg <= offset_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= steer;
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

endmodule

// File: sv/gain_scheduled_pd_steering_unit.sv
// A usable frame passes the square, quotient, remainder, gain, product, sum, scale and
// emit states before m_tvalid rises; a bad frame goes straight to emit. The sequencer
// steps one item at a time through the shared datapath.
// A pending result waits in the output register; a new item may be accepted meanwhile.
// Reset (aresetn low, synchronous): center, previous offset and output history clear to 0.
// ----------------------------------------------------------------------------
// gain_scheduled_pd_steering_unit
// Top level: stream ports, APB register for the center value, sequencer and
// datapath.
// ----------------------------------------------------------------------------
module gain_scheduled_pd_steering_unit
    import gsps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] offset (signed), [15:9] zero
    input  logic        s_tuser,   // [0] frame_ok
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] steer_value
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gsps_cmd_t         cmd;
    gsps_stat_t        stat;
    logic [DATA_W-1:0] center_reg;
    logic              cfg_write;
    logic              sel_center;

    // Register decode: word index zero is the center value
    assign sel_center = !paddr[2];
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
        end else if (cfg_write && sel_center) begin
            center_reg <= pwdata[DATA_W-1:0];
        end
    end

    assign prdata = sel_center ? {16'b0, center_reg} : '0;

    gsps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsps_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_offset   ($signed(s_tdata[OFFSET_W-1:0])),
        .in_frame_ok (s_tuser),
        .center      (center_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_data      (m_tdata)
    );

endmodule
